// ===== rtl/core/stbs_pkg.sv =====
// Shared widths, request codes and the search result type of the sorted table search block.
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 11;

  // Stream payload layout, lowest field first, padded to whole bytes.
  localparam int IN_IDX_LSB  = 0;
  localparam int IN_VAL_LSB  = IN_IDX_LSB + IDX_W;
  localparam int IN_KEY_LSB  = IN_VAL_LSB + DATA_W;
  localparam int IN_DATA_W   = ((IN_KEY_LSB + DATA_W + 7) / 8) * 8;
  localparam int OUT_USED_W  = 1 + IDX_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } result_t;

endpackage

// ===== rtl/core/sorted_table_binary_search.sv =====
// Top level of the sorted table binary search block.
// A write request gives no result; one write can be accepted every cycle while no search is in progress.
// A search probes the table up to 11 times for a 1024-entry table and not at all for an empty
// range, one probe per cycle through the single table read port; no new request is taken until
// its result has moved into the output register. Reset clears control state and active_count;
// the table is not cleared and an entry is defined once written.
module sorted_table_binary_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stbs_pkg::CFG_W-1:0]        cfg_data,       // active_count
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [stbs_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // write_index, write_value, search_key
  input  logic [0:0]                        s_axis_tuser,   // func
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [stbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // found, position
);
  import stbs_pkg::*;

  logic [CFG_W-1:0]  active_count;
  logic [CNT_W-1:0]  count_clip;
  logic              in_req, start, wr_en, rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              busy, res_valid, res_ready;
  result_t           res, out_res;
  logic              out_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      active_count <= cfg_data;
    end
  end

  // A count beyond the table covers the whole table.
  assign count_clip = (int'(active_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(active_count);

  assign s_axis_tready = !busy;
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign start         = in_req && (s_axis_tuser[0] == FUNC_SEARCH);
  assign wr_en         = in_req && (s_axis_tuser[0] == FUNC_WRITE);

  stbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s_axis_tdata[IN_IDX_LSB +: IDX_W]),
    .wr_data (s_axis_tdata[IN_VAL_LSB +: DATA_W]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stbs_search u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .key       ($signed(s_axis_tdata[IN_KEY_LSB +: DATA_W])),
    .count     (count_clip),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: a result waits here while the next request is taken in.
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'({out_res.position, out_res.found});

endmodule

// ===== rtl/core/stbs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/stbs_search.sv =====
// Binary search sequencer: one table probe per cycle, window kept as base and size.
module stbs_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [stbs_pkg::DATA_W-1:0]  key,
  input  logic [stbs_pkg::CNT_W-1:0]          count,
  output logic                                rd_en,
  output logic [stbs_pkg::IDX_W-1:0]          rd_addr,
  input  logic [stbs_pkg::DATA_W-1:0]         rd_data,
  output logic                                busy,
  output logic                                res_valid,
  input  logic                                res_ready,
  output stbs_pkg::result_t                   res
);
  import stbs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0]               state, state_next;
  logic signed [DATA_W-1:0] key_r, key_r_next;
  logic [CNT_W-1:0]         base, base_next;
  logic [CNT_W-1:0]         size, size_next;
  logic [CNT_W-1:0]         probe_at, probe_at_next;
  logic                     hit, hit_next;
  logic [IDX_W-1:0]         hit_pos, hit_pos_next;

  logic [CNT_W-1:0] mid, lo_at, hi_base, hi_size, hi_at;
  logic             key_lt, key_gt;

  // Both possible next probes come from registers only; the compare just selects one.
  assign mid     = size >> 1;
  assign lo_at   = base + (mid >> 1);
  assign hi_base = probe_at + CNT_W'(1);
  assign hi_size = size - mid - CNT_W'(1);
  assign hi_at   = hi_base + (hi_size >> 1);

  assign key_lt = key_r < $signed(rd_data);
  assign key_gt = $signed(rd_data) < key_r;

  always_comb begin
    state_next    = state;
    key_r_next    = key_r;
    base_next     = base;
    size_next     = size;
    probe_at_next = probe_at;
    hit_next      = hit;
    hit_pos_next  = hit_pos;
    rd_en         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          key_r_next    = key;
          base_next     = '0;
          size_next     = count;
          probe_at_next = count >> 1;
          hit_next      = 1'b0;
          hit_pos_next  = '0;
          if (count != '0) begin
            rd_en      = 1'b1;
            state_next = ST_PROBE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_PROBE: begin
        if (key_lt) begin
          size_next     = mid;
          probe_at_next = lo_at;
          if (mid == '0) begin
            state_next = ST_DONE;
          end else begin
            rd_en = 1'b1;
          end
        end else if (key_gt) begin
          base_next     = hi_base;
          size_next     = hi_size;
          probe_at_next = hi_at;
          if (hi_size == '0) begin
            state_next = ST_DONE;
          end else begin
            rd_en = 1'b1;
          end
        end else begin
          hit_next     = 1'b1;
          hit_pos_next = probe_at[IDX_W-1:0];
          state_next   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rd_addr   = probe_at_next[IDX_W-1:0];
  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res.found    = hit;
  assign res.position = hit_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    key_r    <= key_r_next;
    base     <= base_next;
    size     <= size_next;
    probe_at <= probe_at_next;
    hit      <= hit_next;
    hit_pos  <= hit_pos_next;
  end

`ifndef SYNTHESIS
  // The search window never reaches past the end of the table.
  a_window_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |->
      (({1'b0, base} + {1'b0, size}) <= (CNT_W + 1)'(TABLE_DEPTH)))
    else $error("search window runs past the table");

  // The probed entry lies inside the current window.
  a_probe_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |->
      (probe_at >= base && ({1'b0, probe_at} < ({1'b0, base} + {1'b0, size}))))
    else $error("probe outside the search window");

  // A miss always reports position zero.
  a_miss_position: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.found) |-> (res.position == '0))
    else $error("miss reported with a nonzero position");

  // A read is issued only together with a probe cycle that follows it.
  a_read_leads_probe: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == ST_PROBE))
    else $error("table read without a following probe");
`endif

endmodule

// ===== tb/sv/tb_sorted_table_binary_search.sv =====
// Self-checking testbench for the sorted table binary search block with a search scoreboard.
`timescale 1ns / 100ps

module tb_sorted_table_binary_search;
  import stbs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned SETTLE       = 20;
  localparam int unsigned SEARCH_GOAL  = 200;
  localparam int unsigned SHOWN_ERRORS = 10;

  // Keeps a copy of the table and active_count and predicts every search result.
  class search_scoreboard;
    logic signed [DATA_W-1:0] words [TABLE_DEPTH];
    int unsigned              span;
    result_t                  pending [$];
    int unsigned              mismatches;

    function new();
      span       = 0;
      mismatches = 0;
    endfunction

    function void set_count(input logic [CFG_W-1:0] value);
      span = value;
    endfunction

    function void note_request(input logic func, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] key);
      int unsigned              size;
      int unsigned              base;
      int unsigned              half;
      int unsigned              probe;
      logic signed [DATA_W-1:0] probed;
      logic signed [DATA_W-1:0] wanted;
      result_t                  outcome;
      if (func == FUNC_WRITE) begin
        words[idx] = value;
      end else begin
        wanted  = key;
        size    = (span > TABLE_DEPTH) ? TABLE_DEPTH : span;
        base    = 0;
        outcome = '0;
        while (size != 0 && !outcome.found) begin
          half   = size / 2;
          probe  = base + half;
          probed = (probe < TABLE_DEPTH) ? words[probe] : '0;
          if (wanted < probed) begin
            size = half;
          end else if (wanted > probed) begin
            base = probe + 1;
            size = size - (half + 1);
          end else begin
            outcome.found    = 1'b1;
            outcome.position = probe[IDX_W-1:0];
          end
        end
        pending.push_back(outcome);
      end
    endfunction

    function void check_result(input logic [OUT_DATA_W-1:0] data);
      result_t seen;
      result_t due;
      seen.found    = data[0];
      seen.position = data[IDX_W:1];
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("ERROR: result found=%0d position=%0d with no search pending",
                   seen.found, seen.position);
      end else begin
        due = pending.pop_front();
        if (seen.found !== due.found || seen.position !== due.position) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("ERROR: expected found=%0d position=%0d, got found=%0d position=%0d",
                     due.found, due.position, seen.found, seen.position);
        end
      end
    endfunction
  endclass

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  search_scoreboard board;
  bit               calm;
  int unsigned      cycles;
  int unsigned      searches_sent;
  int unsigned      filled_top;

  sorted_table_binary_search i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit hold_off();
    return !calm && ($urandom_range(0, 99) < 35);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_table_binary_search regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_off();
    end
  end

  // Outputs only move at the rising edge, so a handshake seen here completes at the next one.
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata);
  end

  task automatic push_request(input logic func, input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] key);
    while (hold_off()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {{(IN_DATA_W - IN_KEY_LSB - DATA_W){1'b0}}, key, value, idx};
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    board.note_request(func, idx, value, key);
    if (func == FUNC_SEARCH)
      searches_sent++;
    else if (idx >= filled_top)
      filled_top = idx + 1;
  endtask

  // Writes take no result, so a short pause after the last result lets the block go idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(input int unsigned count);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= count[CFG_W-1:0];
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_count(count[CFG_W-1:0]);
  endtask

  // Rewrites entries below need, mostly ascending, sometimes constant or scrambled.
  task automatic lay_out_table(input int unsigned need);
    longint      level;
    int unsigned stride;
    int unsigned style;
    int unsigned i;
    logic [DATA_W-1:0] value;
    if (need == 0)
      return;
    style = $urandom_range(0, 7);
    level = ($urandom_range(0, 3) == 0) ? -64'sd2147483648 : longint'($signed($urandom()));
    case (style)
      0: stride = 0;
      1: stride = 0;
      2, 3: stride = 3;
      4, 5: stride = 1000;
      default: begin
        stride = 32'hFFFF_FFFF / need;
        level  = -64'sd2147483648 + $urandom_range(0, 1000);
      end
    endcase
    for (i = 0; i < need; i++) begin
      value = (style == 1) ? $urandom() : level[DATA_W-1:0];
      push_request(FUNC_WRITE, i[IDX_W-1:0], value, $urandom());
      level = level + $urandom_range(0, stride);
      if (level > 64'sd2147483647)
        level = 64'sd2147483647;
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_key(input int unsigned need);
    int unsigned       roll;
    logic [DATA_W-1:0] stored;
    roll = $urandom_range(0, 99);
    if (need == 0 || roll >= 80)
      return $urandom();
    stored = board.words[$urandom_range(0, need - 1)];
    if (roll < 55)
      return stored;
    if (roll < 70)
      return ($urandom_range(0, 1) == 0) ? stored + 1 : stored - 1;
    case ($urandom_range(0, 2))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return '0;
    endcase
  endfunction

  task automatic run_phase(input int unsigned count, input int unsigned searches);
    int unsigned need;
    int unsigned n;
    need = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    if (need > filled_top || (need <= 128 && $urandom_range(0, 2) == 0))
      lay_out_table(need);
    write_count(count);
    for (n = 0; n < searches; n++) begin
      calm = (searches_sent >= 60 && searches_sent < 140);
      if (need != 0 && $urandom_range(0, 99) < 8)
        push_request(FUNC_WRITE, IDX_W'($urandom_range(0, filled_top - 1)), $urandom(),
                     $urandom());
      else
        push_request(FUNC_SEARCH, IDX_W'($urandom()), $urandom(), pick_key(need));
    end
  endtask

  initial begin
    int unsigned roll;
    int unsigned count;
    int unsigned phase;
    board         = new();
    calm          = 1'b0;
    searches_sent = 0;
    filled_top    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty range straight after reset: every search misses without a probe.
    push_request(FUNC_SEARCH, '1, '1, 32'h0000_0000);
    push_request(FUNC_SEARCH, '0, '0, 32'h7FFF_FFFF);
    // Small table with the value extremes and a duplicate pair.
    push_request(FUNC_WRITE, 10'd0, 32'h8000_0000, '0);
    push_request(FUNC_WRITE, 10'd1, 32'hFFFF_FFFB, '1);
    push_request(FUNC_WRITE, 10'd2, 32'hFFFF_FFFB, '0);
    push_request(FUNC_WRITE, 10'd3, 32'h0000_0007, '1);
    push_request(FUNC_WRITE, 10'd4, 32'h7FFF_FFFF, '0);
    write_count(1);
    push_request(FUNC_SEARCH, '0, '0, 32'h8000_0000);
    push_request(FUNC_SEARCH, '0, '0, 32'h7FFF_FFFF);
    write_count(5);
    push_request(FUNC_SEARCH, '0, '0, 32'hFFFF_FFFB);
    push_request(FUNC_SEARCH, '0, '0, 32'h0000_0007);
    push_request(FUNC_SEARCH, '0, '0, 32'h7FFF_FFFF);
    push_request(FUNC_SEARCH, '0, '0, 32'h8000_0000);
    push_request(FUNC_SEARCH, '0, '0, 32'h0000_0000);
    push_request(FUNC_SEARCH, '0, '0, 32'h7FFF_FFFE);
    // Out of order entries still follow the same probe sequence.
    push_request(FUNC_WRITE, 10'd1, 32'h0000_0100, '0);
    push_request(FUNC_SEARCH, '0, '0, 32'h0000_0100);
    push_request(FUNC_SEARCH, '0, '0, 32'h0000_0007);
    write_count(0);
    push_request(FUNC_SEARCH, '0, '0, 32'h0000_0007);

    phase = 0;
    while (searches_sent < SEARCH_GOAL || phase <= 4) begin
      if (phase == 4) begin
        // Whole table, then counts beyond the depth that must clamp to it.
        run_phase(TABLE_DEPTH, 60);
        run_phase(2047, 30);
        run_phase(TABLE_DEPTH + 1, 10);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 8)
          count = 0;
        else if (roll < 15)
          count = 1;
        else if (roll < 30)
          count = $urandom_range(2, 8);
        else if (roll < 85)
          count = $urandom_range(9, 64);
        else
          count = $urandom_range(65, 300);
        run_phase(count, $urandom_range(10, 50));
      end
      phase++;
    end

    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("sorted_table_binary_search regression: pass");
    end else begin
      $display("sorted_table_binary_search regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/stbs_pkg.sv
rtl/core/stbs_ram.sv
rtl/core/stbs_search.sv
rtl/core/sorted_table_binary_search.sv
tb/sv/tb_sorted_table_binary_search.sv
